[hdl/serial_line_assembler_assert.svh]
// Assertion helpers for the checker module.
`ifndef SERIAL_LINE_ASSEMBLER_ASSERT_SVH
`define SERIAL_LINE_ASSEMBLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLA_CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLA_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sla_pkg.sv]
package sla_pkg;

    // Field widths
    localparam int PORT_W = 1;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 6;

    // Largest line the 6-bit fields can describe
    localparam int MAX_LINE = 63;

    // Port slots reachable through the port field
    localparam int NUM_SLOTS = 2;

    // Control characters
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;

    // Write request into the position table
    typedef struct packed {
        logic              en;
        logic [PORT_W-1:0] port;
        logic [POS_W-1:0]  pos;
    } t_pos_wr;

endpackage

[hdl/sla_line_ram.sv]
module sla_line_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [sla_pkg::BYTE_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [sla_pkg::BYTE_W-1:0]  o_rdata
);

    logic [sla_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [sla_pkg::BYTE_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/sla_pos_table.sv]
module sla_pos_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [sla_pkg::PORT_W-1:0]   i_rd_port,
    output logic [sla_pkg::POS_W-1:0]    o_rd_pos,
    input  sla_pkg::t_pos_wr             i_wr
);

    logic [sla_pkg::POS_W-1:0] r_pos [sla_pkg::NUM_SLOTS];

    // Per-port write positions, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sla_pkg::NUM_SLOTS; i++) begin
                r_pos[i] <= '0;
            end
        end else if (i_wr.en) begin
            r_pos[i_wr.port] <= i_wr.pos;
        end
    end

    assign o_rd_pos = r_pos[i_rd_port];

endmodule

[hdl/serial_line_assembler.sv]
// Channel | Handshake              | Payload
// --------+------------------------+--------------------------------------------------
// in      | i_in_valid, o_in_stall | i_port, i_rx_byte
// out     | o_out_valid, i_out_stall | o_line_port, o_line_char, o_char_index,
//         |                        |   o_line_length, o_last
//
// A byte is taken every cycle while no line is being read out.
// A terminator closing a non-empty line stalls the input until the line's last
// character is read: the line store has one read port and the sequencer reads one
// character per cycle unless output stalls, via a read stage and an output register.
// Output stalls pause the read sequencer; nothing is dropped.
// Reset clears positions and control state; the line store is not cleared.
module serial_line_assembler #(
    parameter int LINE_SIZE = 64,
    parameter int PORTS     = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [sla_pkg::PORT_W-1:0]   i_port,
    input  logic [sla_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [sla_pkg::PORT_W-1:0]   o_line_port,
    output logic [sla_pkg::BYTE_W-1:0]   o_line_char,
    output logic [sla_pkg::POS_W-1:0]    o_char_index,
    output logic [sla_pkg::POS_W-1:0]    o_line_length,
    output logic                         o_last
);

    localparam int DEPTH    = PORTS * LINE_SIZE;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LINE_CAP = (LINE_SIZE - 1 > sla_pkg::MAX_LINE) ? sla_pkg::MAX_LINE
                                                                 : LINE_SIZE - 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    localparam int PW = sla_pkg::POS_W;

    logic                        r_state, n_state;
    logic [sla_pkg::PORT_W-1:0]  r_port;
    logic [PW-1:0]               r_len;
    logic [PW-1:0]               r_k;

    logic                        r_rd_pend, n_rd_pend;
    logic [sla_pkg::PORT_W-1:0]  r_rd_port;
    logic [PW-1:0]               r_rd_idx;
    logic [PW-1:0]               r_rd_len;
    logic                        r_rd_last;

    logic                        r_out_valid, n_out_valid;
    logic [sla_pkg::PORT_W-1:0]  r_out_port;
    logic [sla_pkg::BYTE_W-1:0]  r_out_char;
    logic [PW-1:0]               r_out_idx;
    logic [PW-1:0]               r_out_len;
    logic                        r_out_last;

    logic                        in_acc;
    logic                        port_ok;
    logic                        is_term;
    logic                        is_erase;
    logic [PW-1:0]               cur_pos;
    logic                        pos_nz;
    logic                        do_append;
    logic                        do_start;
    sla_pkg::t_pos_wr            pos_wr;

    logic                        take;
    logic                        move;
    logic                        issue;
    logic                        issue_last;
    logic [AW-1:0]               waddr;
    logic [AW-1:0]               raddr;
    logic [sla_pkg::BYTE_W-1:0]  rdata;

    // Input decode
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign port_ok    = (PORTS > 1) || (i_port == '0);
    assign is_term    = (i_rx_byte == sla_pkg::CH_CR) || (i_rx_byte == sla_pkg::CH_LF);
    assign is_erase   = (i_rx_byte == sla_pkg::CH_BS) || (i_rx_byte == sla_pkg::CH_DEL);
    assign pos_nz     = (cur_pos != '0);
    assign do_append  = in_acc && port_ok && !is_term && !is_erase
                        && (cur_pos < PW'(LINE_CAP));
    assign do_start   = in_acc && port_ok && is_term && pos_nz;

    // Position update: clear on a closed line, step back on erase, step on append
    always_comb begin
        pos_wr.en   = do_append || do_start || (in_acc && port_ok && is_erase && pos_nz);
        pos_wr.port = i_port;
        if (is_term) begin
            pos_wr.pos = '0;
        end else if (is_erase) begin
            pos_wr.pos = cur_pos - PW'(1);
        end else begin
            pos_wr.pos = cur_pos + PW'(1);
        end
    end

    sla_pos_table u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_port (i_port),
        .o_rd_pos  (cur_pos),
        .i_wr      (pos_wr)
    );

    // Line store addressing: port base plus character position
    assign waddr = ((i_port != '0) ? AW'(LINE_SIZE) : AW'(0)) + AW'(cur_pos);
    assign raddr = ((r_port != '0) ? AW'(LINE_SIZE) : AW'(0)) + AW'(r_k);

    sla_line_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (do_append),
        .i_waddr (waddr),
        .i_wdata (i_rx_byte),
        .i_re    (issue),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Read-out flow: a read is issued only when its data will have a place to go
    assign take       = r_out_valid && !i_out_stall;
    assign move       = r_rd_pend && (!r_out_valid || take);
    assign issue      = (r_state == ST_EMIT) && (!r_rd_pend || move);
    assign issue_last = (r_k == r_len - PW'(1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (do_start) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (issue && issue_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_rd_pend   = issue || (r_rd_pend && !move);
        n_out_valid = move || (r_out_valid && !take);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Sequencer payload
    always_ff @(posedge i_clk) begin
        if (do_start) begin
            r_port <= i_port;
            r_len  <= cur_pos;
            r_k    <= '0;
        end else if (issue) begin
            r_k <= r_k + PW'(1);
        end
        if (issue) begin
            r_rd_port <= r_port;
            r_rd_idx  <= r_k;
            r_rd_len  <= r_len;
            r_rd_last <= issue_last;
        end
        if (move) begin
            r_out_port <= r_rd_port;
            r_out_char <= rdata;
            r_out_idx  <= r_rd_idx;
            r_out_len  <= r_rd_len;
            r_out_last <= r_rd_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_line_port   = r_out_port;
    assign o_line_char   = r_out_char;
    assign o_char_index  = r_out_idx;
    assign o_line_length = r_out_len;
    assign o_last        = r_out_last;

endmodule

[hdl/sla_checker.sv]
`include "serial_line_assembler_assert.svh"

module sla_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         o_in_stall,
    input  logic [sla_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic                         o_out_valid,
    input  logic                         i_out_stall,
    input  logic [sla_pkg::PORT_W-1:0]   o_line_port,
    input  logic [sla_pkg::BYTE_W-1:0]   o_line_char,
    input  logic [sla_pkg::POS_W-1:0]    o_char_index,
    input  logic [sla_pkg::POS_W-1:0]    o_line_length,
    input  logic                         o_last
);

    // A stalled result stays put
    `SLA_CHK_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_line_char) && $stable(o_char_index) && $stable(o_line_port),
        "stalled result changed")

    // Index lies inside the line
    `SLA_CHK_SAME(a_idx_range, o_out_valid, o_char_index < o_line_length,
        "char index beyond line length")

    // Last flag marks exactly the final character
    `SLA_CHK_SAME(a_last_mark, o_out_valid, o_last == (o_char_index + 6'd1 == o_line_length),
        "last flag disagrees with index")

    // A taken non-final character is followed by its successor or a gap, never a new line start
    `SLA_CHK_NEXT(a_seq_step, o_out_valid && !i_out_stall && !o_last,
        !o_out_valid || (o_char_index == $past(o_char_index) + 6'd1),
        "character sequence broken")

    // Input stall only starts after a terminator request was offered
    `SLA_CHK_NEXT(a_stall_cause, !o_in_stall && !(i_in_valid &&
        (i_rx_byte == sla_pkg::CH_CR || i_rx_byte == sla_pkg::CH_LF)),
        !o_in_stall, "input stalled without a line to emit")

endmodule

bind serial_line_assembler sla_checker u_sla_checker (.*);

[verif/serial_line_assembler_tb.sv]
`timescale 1ns / 1ps

module serial_line_assembler_tb;

    localparam int LINE_SIZE   = 64;
    localparam int PORTS       = 2;
    localparam int LINE_CAP    = (LINE_SIZE - 1 > sla_pkg::MAX_LINE) ? sla_pkg::MAX_LINE
                                                                    : LINE_SIZE - 1;
    localparam int RX_TARGET   = 230;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 16;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 400;

    // One received byte or a drain marker, plus the gap before the next one
    typedef struct {
        logic [sla_pkg::PORT_W-1:0] src;
        logic [sla_pkg::BYTE_W-1:0] rx;
        int unsigned                gap;
        bit                         drain;
    } t_rx_req;

    // One character of a completed line
    typedef struct {
        logic [sla_pkg::PORT_W-1:0] src;
        logic [sla_pkg::BYTE_W-1:0] ch;
        logic [sla_pkg::POS_W-1:0]  idx;
        logic [sla_pkg::POS_W-1:0]  len;
        logic                       last;
    } t_line_char;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [sla_pkg::PORT_W-1:0] i_port;
    logic [sla_pkg::BYTE_W-1:0] i_rx_byte;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [sla_pkg::PORT_W-1:0] o_line_port;
    logic [sla_pkg::BYTE_W-1:0] o_line_char;
    logic [sla_pkg::POS_W-1:0]  o_char_index;
    logic [sla_pkg::POS_W-1:0]  o_line_length;
    logic                       o_last;

    // Predictor state: one line buffer and fill count per port
    logic [sla_pkg::BYTE_W-1:0] line_mem [PORTS][LINE_CAP];
    int unsigned                fill [PORTS];

    t_rx_req     rx_backlog [$];
    t_line_char  line_chars_due [$];
    t_rx_req     cur_req;
    t_line_char  want;

    logic        in_fire = 1'b0;
    logic        out_fire = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned reqs_built = 0;
    int unsigned reqs_taken = 0;
    int unsigned chars_seen = 0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;

    serial_line_assembler #(
        .LINE_SIZE(LINE_SIZE),
        .PORTS    (PORTS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_port       (i_port),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_line_port  (o_line_port),
        .o_line_char  (o_line_char),
        .o_char_index (o_char_index),
        .o_line_length(o_line_length),
        .o_last       (o_last)
    );

    // Clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Line assembly as the block should do it; pushes the characters a request releases
    function automatic void assemble_byte(logic [sla_pkg::PORT_W-1:0] src,
                                          logic [sla_pkg::BYTE_W-1:0] rx);
        t_line_char  c;
        int unsigned n;
        if (src >= PORTS)
            return;
        n = fill[src];
        if (rx == sla_pkg::CH_CR || rx == sla_pkg::CH_LF) begin
            for (int unsigned k = 0; k < n; k++) begin
                c.src  = src;
                c.ch   = line_mem[src][k];
                c.idx  = k[sla_pkg::POS_W-1:0];
                c.len  = n[sla_pkg::POS_W-1:0];
                c.last = (k + 1 == n);
                line_chars_due.push_back(c);
            end
            fill[src] = 0;
        end else if (rx == sla_pkg::CH_BS || rx == sla_pkg::CH_DEL) begin
            if (n > 0)
                fill[src] = n - 1;
        end else if (n < LINE_CAP) begin
            line_mem[src][n] = rx;
            fill[src] = n + 1;
        end
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            err_count++;
        end
    endfunction

    // Sender gap: a run of back-to-back requests in the middle, random elsewhere
    function automatic int unsigned draw_gap();
        if (reqs_built >= 100 && reqs_built < 140)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // Receiver stall before the next character: quiet stretches, random elsewhere
    function automatic int unsigned draw_stall();
        if (chars_seen % 96 < 32)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // Any byte value
    function automatic logic [sla_pkg::BYTE_W-1:0] any_byte();
        int unsigned v;
        v = $urandom_range(0, 255);
        return v[sla_pkg::BYTE_W-1:0];
    endfunction

    // Printable or binary text byte, never a terminator or an erase code
    function automatic logic [sla_pkg::BYTE_W-1:0] text_byte();
        logic [sla_pkg::BYTE_W-1:0] b;
        b = any_byte();
        while (b == sla_pkg::CH_CR || b == sla_pkg::CH_LF ||
               b == sla_pkg::CH_BS || b == sla_pkg::CH_DEL)
            b = any_byte();
        return b;
    endfunction

    function automatic int unsigned draw_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(55, 70);
        return $urandom_range(0, 9);
    endfunction

    task automatic add_req(int unsigned src, logic [sla_pkg::BYTE_W-1:0] rx);
        t_rx_req r;
        r.src   = src[sla_pkg::PORT_W-1:0];
        r.rx    = rx;
        r.gap   = draw_gap();
        r.drain = 1'b0;
        rx_backlog.push_back(r);
        reqs_built++;
    endtask

    // Marker: sender waits here until every pending line has come out
    task automatic add_drain();
        t_rx_req r;
        r.src   = '0;
        r.rx    = '0;
        r.gap   = 0;
        r.drain = 1'b1;
        rx_backlog.push_back(r);
    endtask

    // Monitor: sample both handshakes, check outputs, feed the predictor
    always @(posedge i_clk) begin
        in_fire  = i_rst_n && i_in_valid && !o_in_stall;
        out_fire = i_rst_n && o_out_valid && !i_out_stall;
        if (out_fire) begin
            chars_seen++;
            if (line_chars_due.size() == 0) begin
                $error("unexpected character: port %0d char 0x%02h index %0d",
                       o_line_port, o_line_char, o_char_index);
                err_count++;
            end else begin
                want = line_chars_due.pop_front();
                check_field("line_port", 32'(want.src), 32'(o_line_port));
                check_field("line_char", 32'(want.ch), 32'(o_line_char));
                check_field("char_index", 32'(want.idx), 32'(o_char_index));
                check_field("line_length", 32'(want.len), 32'(o_line_length));
                check_field("last", 32'(want.last), 32'(o_last));
            end
        end
        if (in_fire) begin
            assemble_byte(i_port, i_rx_byte);
            reqs_taken++;
        end
    end

    // Driver: offer requests from the backlog, holding each until taken
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !in_fire)) begin
            if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left--;
            end else if (rx_backlog.size() > 0 && rx_backlog[0].drain) begin
                i_in_valid <= 1'b0;
                if (line_chars_due.size() == 0)
                    void'(rx_backlog.pop_front());
            end else if (rx_backlog.size() > 0) begin
                cur_req = rx_backlog.pop_front();
                i_port     <= cur_req.src;
                i_rx_byte  <= cur_req.rx;
                i_in_valid <= 1'b1;
                gap_left   = cur_req.gap;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall per character, plus one long hold-off to back up the block
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!hold_done && reqs_taken >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (out_fire)
                stall_left = draw_stall();
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("serial_line_assembler_tb: done, errors");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int unsigned target [PORTS];
        int unsigned made [PORTS];
        int unsigned p;
        int unsigned r;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_port      = '0;
        i_rx_byte   = '0;
        i_out_stall = 1'b0;
        for (int i = 0; i < PORTS; i++)
            fill[i] = 0;

        // Ending or erasing an empty line does nothing
        add_req(0, sla_pkg::CH_CR);
        add_req(1, sla_pkg::CH_LF);
        add_req(0, sla_pkg::CH_BS);
        add_req(1, sla_pkg::CH_DEL);
        // Interleaved lines with byte extremes, each erase code once
        add_req(0, 8'h41);
        add_req(1, 8'h00);
        add_req(0, 8'hFF);
        add_req(1, 8'h7E);
        add_req(0, sla_pkg::CH_BS);
        add_req(1, sla_pkg::CH_DEL);
        add_req(0, 8'h80);
        add_req(0, 8'h01);
        add_req(0, sla_pkg::CH_LF);
        add_req(1, sla_pkg::CH_CR);
        // Single-character line
        add_req(1, 8'h5A);
        add_req(1, sla_pkg::CH_LF);
        add_drain();

        // Full line: overflow dropped, erase then refill to the limit
        for (int k = 0; k < LINE_CAP + 3; k++)
            add_req(0, text_byte());
        add_req(0, sla_pkg::CH_DEL);
        add_req(0, text_byte());
        add_req(0, text_byte());
        add_req(0, sla_pkg::CH_CR);

        // Random interleaved lines with erases and some noise
        for (int i = 0; i < PORTS; i++) begin
            target[i] = draw_len();
            made[i]   = 0;
        end
        while (reqs_built < RX_TARGET) begin
            p = $urandom_range(0, PORTS - 1);
            r = $urandom_range(0, 19);
            if (r == 0) begin
                add_req(p, any_byte());
            end else if (made[p] < target[p]) begin
                if (r == 1 && made[p] > 0) begin
                    add_req(p, $urandom_range(0, 1) ? sla_pkg::CH_BS : sla_pkg::CH_DEL);
                    made[p]--;
                end else begin
                    add_req(p, text_byte());
                    made[p]++;
                end
            end else begin
                add_req(p, $urandom_range(0, 1) ? sla_pkg::CH_CR : sla_pkg::CH_LF);
                made[p]   = 0;
                target[p] = draw_len();
            end
            if (reqs_built == 150)
                add_drain();
        end
        add_req(0, sla_pkg::CH_CR);
        add_req(1, sla_pkg::CH_LF);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to be taken and every line to come out
        @(negedge i_clk);
        while (reqs_taken != reqs_built || line_chars_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);

        if (line_chars_due.size() != 0) begin
            $error("%0d characters never came out", line_chars_due.size());
            err_count++;
        end
        if (err_count == 0)
            $display("serial_line_assembler_tb: done, clean");
        else
            $display("serial_line_assembler_tb: done, errors");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/sla_pkg.sv
hdl/sla_line_ram.sv
hdl/sla_pos_table.sv
hdl/serial_line_assembler.sv
hdl/sla_checker.sv
verif/serial_line_assembler_tb.sv
